// ===== rtl/npg_pkg.sv =====
// package: types and constants for the next permutation generator
`timescale 1ns / 1ps

package npg_pkg;

	localparam int unsigned SYM_W = 8;

	// opcode carried on s_tuser
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	// bit places of the result flags on m_tuser
	localparam int unsigned FLAG_EXH = 0;
	localparam int unsigned FLAG_OVF = 1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SORT_INIT,
		ST_SORT_RDA,
		ST_SORT_KEY,
		ST_SORT_RDB,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_PIV_RD0,
		ST_PIV_CUR,
		ST_PIV_RD,
		ST_PIV_CMP,
		ST_SWP_RD,
		ST_SWP_CMP,
		ST_SWP_W1,
		ST_SWP_W2,
		ST_REV_CHK,
		ST_REV_RDA,
		ST_REV_RDB,
		ST_REV_WA,
		ST_REV_WB,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EXH
	} state_t;

endpackage

// ===== rtl/next_permutation_generator_unit.sv =====
// top level: stores a symbol string and emits its lexicographic permutations
`timescale 1ns / 1ps

// channel | dir | tdata            | tuser                        | tlast
// s_*     | in  | [7:0] symbol     | [0] opcode (0 load, 1 next)  | end_of_string
// m_*     | out | [7:0] out_symbol | [0] exhausted, [1] overflow  | last_of_run
//
// a load that closes a string of length L sorts it (insertion sort through the store)
// a request scans back for the pivot, scans the suffix for the swap target, swaps the
// two, reverses the suffix pair by pair and emits every symbol; all of it is paced
// by one registered store read port
// the first request after a close only emits; an exhausted reply is a single zero item
// arst_n clears the string length and all string flags; the store itself is not cleared
// s_tready is low while a request or sort is in progress; a stalled m_tready holds the
// sequencer in its emit or exhausted state

module next_permutation_generator_unit #(
	parameter int unsigned MAX_LEN = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [npg_pkg::SYM_W-1:0] s_tdata,  // [7:0] symbol
	input  logic                      s_tuser,  // [0] opcode
	input  logic                      s_tlast,  // end_of_string
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [npg_pkg::SYM_W-1:0] m_tdata,  // [7:0] out_symbol
	output logic [1:0]                m_tuser,  // [0] exhausted, [1] overflow
	output logic                      m_tlast   // last_of_run
);

	localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int unsigned LW = $clog2(MAX_LEN + 1);
	localparam int unsigned SW = npg_pkg::SYM_W;

	npg_pkg::state_t state_q, state_d;

	// string state
	logic [LW-1:0] len_q;
	logic          closed_q;
	logic          first_q;
	logic          done_q;
	logic          ovf_q;

	// sequencer working registers
	logic [AW-1:0] i_q;      // sort outer index, scan index, suffix low end, emit index
	logic [AW-1:0] j_q;      // sort insert index, swap target, suffix high end
	logic [AW-1:0] piv_q;    // pivot position
	logic [SW-1:0] key_q;    // sort key, right neighbor during scan, swap value
	logic [SW-1:0] pv_q;     // pivot value

	// symbol store: one write and one registered read port
	logic [SW-1:0] mem [MAX_LEN];
	logic [SW-1:0] rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [SW-1:0] mem_wd;
	logic [AW-1:0] rd_addr;

	// output register
	logic          m_valid_q;
	logic [SW-1:0] m_data_q;
	logic          m_last_q;
	logic          m_exh_q;
	logic          m_ovf_q;
	logic          out_free;
	logic          out_load;
	logic [SW-1:0] out_sym;
	logic          out_last;
	logic          out_exh;

	logic          in_acc;
	logic          is_load;
	logic [AW-1:0] last_idx;
	logic          room;

	// shared magnitude compare of the store read data
	logic [SW-1:0] cmp_b;
	logic          cmp_gt;
	logic          cmp_lt;

	assign in_acc   = s_tvalid & s_tready;
	assign is_load  = (s_tuser == npg_pkg::OP_LOAD);
	assign last_idx = AW'(len_q - LW'(1));
	assign room     = closed_q || (len_q < LW'(MAX_LEN));
	assign out_free = !m_valid_q || m_tready;

	assign cmp_b  = (state_q == npg_pkg::ST_SWP_CMP) ? pv_q : key_q;
	assign cmp_gt = (rdata_q > cmp_b);
	assign cmp_lt = !cmp_gt && (rdata_q != cmp_b);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npg_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (is_load) begin
						if (s_tlast) begin
							state_d = npg_pkg::ST_SORT_INIT;
						end
					end else if (!closed_q || len_q == '0 || done_q) begin
						state_d = npg_pkg::ST_EXH;
					end else if (!first_q) begin
						state_d = npg_pkg::ST_EMIT_RD;
					end else if (len_q < LW'(2)) begin
						state_d = npg_pkg::ST_EXH;
					end else begin
						state_d = npg_pkg::ST_PIV_RD0;
					end
				end
			end
			npg_pkg::ST_SORT_INIT: begin
				state_d = (len_q < LW'(2)) ? npg_pkg::ST_IDLE : npg_pkg::ST_SORT_RDA;
			end
			npg_pkg::ST_SORT_RDA: state_d = npg_pkg::ST_SORT_KEY;
			npg_pkg::ST_SORT_KEY: state_d = npg_pkg::ST_SORT_RDB;
			npg_pkg::ST_SORT_RDB: state_d = npg_pkg::ST_SORT_CMP;
			npg_pkg::ST_SORT_CMP: begin
				if (cmp_gt && j_q != AW'(1)) begin
					state_d = npg_pkg::ST_SORT_RDB;
				end else begin
					state_d = npg_pkg::ST_SORT_PUT;
				end
			end
			npg_pkg::ST_SORT_PUT: begin
				state_d = (i_q == last_idx) ? npg_pkg::ST_IDLE : npg_pkg::ST_SORT_RDA;
			end
			npg_pkg::ST_PIV_RD0: state_d = npg_pkg::ST_PIV_CUR;
			npg_pkg::ST_PIV_CUR: state_d = npg_pkg::ST_PIV_RD;
			npg_pkg::ST_PIV_RD:  state_d = npg_pkg::ST_PIV_CMP;
			npg_pkg::ST_PIV_CMP: begin
				if (cmp_lt) begin
					state_d = npg_pkg::ST_SWP_RD;
				end else if (i_q == AW'(1)) begin
					state_d = npg_pkg::ST_EXH;
				end else begin
					state_d = npg_pkg::ST_PIV_RD;
				end
			end
			npg_pkg::ST_SWP_RD:  state_d = npg_pkg::ST_SWP_CMP;
			npg_pkg::ST_SWP_CMP: begin
				state_d = cmp_gt ? npg_pkg::ST_SWP_W1 : npg_pkg::ST_SWP_RD;
			end
			npg_pkg::ST_SWP_W1:  state_d = npg_pkg::ST_SWP_W2;
			npg_pkg::ST_SWP_W2:  state_d = npg_pkg::ST_REV_CHK;
			npg_pkg::ST_REV_CHK: begin
				state_d = (i_q < j_q) ? npg_pkg::ST_REV_RDA : npg_pkg::ST_EMIT_RD;
			end
			npg_pkg::ST_REV_RDA:  state_d = npg_pkg::ST_REV_RDB;
			npg_pkg::ST_REV_RDB:  state_d = npg_pkg::ST_REV_WA;
			npg_pkg::ST_REV_WA:   state_d = npg_pkg::ST_REV_WB;
			npg_pkg::ST_REV_WB:   state_d = npg_pkg::ST_REV_CHK;
			npg_pkg::ST_EMIT_RD:  state_d = npg_pkg::ST_EMIT_OUT;
			npg_pkg::ST_EMIT_OUT: begin
				if (out_free) begin
					state_d = (i_q == last_idx) ? npg_pkg::ST_IDLE : npg_pkg::ST_EMIT_RD;
				end
			end
			npg_pkg::ST_EXH: begin
				if (out_free) begin
					state_d = npg_pkg::ST_IDLE;
				end
			end
			default: state_d = npg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: store ports, output load, input ready
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = j_q;
		mem_wd   = rdata_q;
		rd_addr  = i_q;
		out_load = 1'b0;
		out_sym  = rdata_q;
		out_last = (i_q == last_idx);
		out_exh  = 1'b0;
		unique case (state_q)
			npg_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				// a load into a closed string starts over at entry zero
				mem_we   = in_acc && is_load && room;
				mem_wa   = closed_q ? '0 : AW'(len_q);
				mem_wd   = s_tdata;
			end
			npg_pkg::ST_SORT_RDB: rd_addr = AW'(j_q - AW'(1));
			npg_pkg::ST_SORT_CMP: begin
				// shift the larger neighbor one place right
				mem_we = cmp_gt;
			end
			npg_pkg::ST_SORT_PUT: begin
				mem_we = 1'b1;
				mem_wd = key_q;
			end
			npg_pkg::ST_PIV_RD: rd_addr = AW'(i_q - AW'(1));
			npg_pkg::ST_SWP_RD: rd_addr = j_q;
			npg_pkg::ST_SWP_W1: begin
				mem_we = 1'b1;
				mem_wa = piv_q;
				mem_wd = key_q;
			end
			npg_pkg::ST_SWP_W2: begin
				mem_we = 1'b1;
				mem_wd = pv_q;
			end
			npg_pkg::ST_REV_RDB: rd_addr = j_q;
			npg_pkg::ST_REV_WA: begin
				mem_we = 1'b1;
				mem_wa = i_q;
			end
			npg_pkg::ST_REV_WB: begin
				mem_we = 1'b1;
				mem_wd = key_q;
			end
			npg_pkg::ST_EMIT_OUT: out_load = out_free;
			npg_pkg::ST_EXH: begin
				out_load = out_free;
				out_sym  = '0;
				out_last = 1'b1;
				out_exh  = 1'b1;
			end
			default: ;
		endcase
	end

	// symbol store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[rd_addr];
	end

	// string state and sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= npg_pkg::ST_IDLE;
			len_q    <= '0;
			closed_q <= 1'b0;
			first_q  <= 1'b0;
			done_q   <= 1'b0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			piv_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				npg_pkg::ST_IDLE: begin
					if (in_acc && is_load) begin
						if (closed_q) begin
							len_q <= LW'(1);
							ovf_q <= 1'b0;
						end else if (room) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						closed_q <= s_tlast;
						first_q  <= 1'b0;
						done_q   <= 1'b0;
						i_q      <= AW'(1);
					end else if (in_acc && closed_q && len_q != '0 && !done_q) begin
						if (!first_q) begin
							first_q <= 1'b1;
							i_q     <= '0;
						end else if (len_q < LW'(2)) begin
							done_q <= 1'b1;
						end else begin
							i_q <= last_idx;
						end
					end
				end
				npg_pkg::ST_SORT_KEY: j_q <= i_q;
				npg_pkg::ST_SORT_CMP: begin
					if (cmp_gt) begin
						j_q <= AW'(j_q - AW'(1));
					end
				end
				npg_pkg::ST_SORT_PUT: i_q <= AW'(i_q + AW'(1));
				npg_pkg::ST_PIV_CMP: begin
					if (cmp_lt) begin
						piv_q <= AW'(i_q - AW'(1));
						j_q   <= last_idx;
					end else if (i_q == AW'(1)) begin
						done_q <= 1'b1;
					end else begin
						i_q <= AW'(i_q - AW'(1));
					end
				end
				npg_pkg::ST_SWP_CMP: begin
					if (!cmp_gt) begin
						j_q <= AW'(j_q - AW'(1));
					end
				end
				npg_pkg::ST_SWP_W2: begin
					i_q <= AW'(piv_q + AW'(1));
					j_q <= last_idx;
				end
				npg_pkg::ST_REV_CHK: begin
					if (!(i_q < j_q)) begin
						i_q <= '0;
					end
				end
				npg_pkg::ST_REV_WB: begin
					i_q <= AW'(i_q + AW'(1));
					j_q <= AW'(j_q - AW'(1));
				end
				npg_pkg::ST_EMIT_OUT: begin
					if (out_free) begin
						i_q <= AW'(i_q + AW'(1));
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			npg_pkg::ST_SORT_KEY: key_q <= rdata_q;
			npg_pkg::ST_PIV_CUR:  key_q <= rdata_q;
			npg_pkg::ST_PIV_CMP: begin
				key_q <= rdata_q;
				pv_q  <= rdata_q;
			end
			npg_pkg::ST_SWP_CMP:  key_q <= rdata_q;
			npg_pkg::ST_REV_RDB:  key_q <= rdata_q;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= out_sym;
			m_last_q <= out_last;
			m_exh_q  <= out_exh;
			m_ovf_q  <= ovf_q;
		end
	end

	assign m_tvalid                  = m_valid_q;
	assign m_tdata                   = m_data_q;
	assign m_tlast                   = m_last_q;
	assign m_tuser[npg_pkg::FLAG_EXH] = m_exh_q;
	assign m_tuser[npg_pkg::FLAG_OVF] = m_ovf_q;

	// an exhausted item is always a lone, last, zero item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[npg_pkg::FLAG_EXH] |-> m_tlast && (m_tdata == '0))
		else $error("exhausted item without last marker or with a symbol");

	// string length never exceeds the store
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_LEN))
		else $error("string length beyond capacity");

	// a closing load always leaves the string closed
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == npg_pkg::OP_LOAD) && s_tlast |=> closed_q)
		else $error("closing load did not close the string");

	// the output register is only loaded when it is free
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_valid_q || m_tready))
		else $error("output item overwritten before it was taken");

endmodule
